@@ hw/rtl/fpec_pkg.sv @@
// Shared types, constants and arithmetic helpers for the frustum plane extract and cull core.
package fpec_pkg;

    localparam int W           = 32;
    localparam int F           = 16;
    localparam int AW          = W + 4;
    localparam int RW          = W - 1;
    localparam int MW          = (2 * W - F > W + F) ? 2 * W - F : W + F;
    localparam int CW          = $clog2(W + F);
    localparam int KIND_W      = 3;
    localparam int MAT_DEPTH   = 16;
    localparam int MAT_AW      = $clog2(MAT_DEPTH);
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_DEPTH = PLANE_COUNT * 4;
    localparam int PL_AW       = $clog2(PLANE_DEPTH);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRACT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POINT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPHERE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CORNER  = 3'd4;

    localparam logic [1:0] STATUS_TEST   = 2'd0;
    localparam logic [1:0] STATUS_PLANES = 2'd1;
    localparam logic [1:0] STATUS_DEGEN  = 2'd2;

    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

    localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

    localparam logic [MW-1:0] LIM_POS = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [MW-1:0] LIM_NEG = LIM_POS + MW'(1);
    localparam logic signed [W-1:0]  WORD_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  WORD_MIN = {1'b1, {(W - 1){1'b0}}};
    localparam logic signed [AW-1:0] ACC_MAX  = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN  = ~ACC_MAX;
    localparam logic signed [AW-1:0] ACC_ZERO = '0;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_EXTRACT,
        OP_POINT,
        OP_SPHERE,
        OP_CORNER
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic                    msel;
        logic [MAT_AW-1:0]       eidx;
        logic signed [W-1:0]     x;
        logic signed [W-1:0]     y;
        logic signed [W-1:0]     z;
        logic [RW-1:0]           radius;
        logic                    xz;
        logic                    sphere;
        logic                    last;
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CL_RD,
        ST_CL_MUL,
        ST_CL_ACC,
        ST_PL_RD_W,
        ST_PL_RD_T,
        ST_PL_RAW,
        ST_PL_SQ,
        ST_PL_SQACC,
        ST_SQRT,
        ST_LEN,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_WR,
        ST_T_RA,
        ST_T_RC,
        ST_T_RB,
        ST_T_RD,
        ST_T_EV,
        ST_FINISH
    } t_state;

    function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [MW-1:0] q);
        logic signed [W-1:0] r;
        if (neg) begin
            r = (q > LIM_NEG) ? WORD_MIN : $signed(W'(0) - q[W-1:0]);
        end else begin
            r = (q > LIM_POS) ? WORD_MAX : $signed(q[W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] p);
        logic [2*W-1:0] m;
        m = p[2*W-1] ? $unsigned(-p) : $unsigned(p);
        return sat_mag(p[2*W-1], MW'(m >> F));
    endfunction

    function automatic logic signed [W-1:0] sat_quot(input logic neg, input logic [W+F-1:0] q);
        return sat_mag(neg, MW'(q));
    endfunction

    function automatic logic signed [W-1:0] sat_acc(input logic signed [AW-1:0] a);
        logic signed [W-1:0] r;
        if (a > ACC_MAX) begin
            r = WORD_MAX;
        end else if (a < ACC_MIN) begin
            r = WORD_MIN;
        end else begin
            r = a[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] word_ext(input logic signed [W-1:0] v);
        return {{(AW - W){v[W-1]}}, v};
    endfunction

    function automatic logic [1:0] plane_col(input logic [2:0] p);
        return p[2:1];
    endfunction

    function automatic logic plane_add(input logic [2:0] p);
        logic r;
        unique case (p)
            3'd1, 3'd2, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] test_plane(input logic [2:0] ti, input logic xz);
        logic [2:0] r;
        if (xz && ti == 3'd2) begin
            r = 3'd4;
        end else begin
            r = ti;
        end
        return r;
    endfunction

    function automatic logic test_last(input logic [2:0] ti, input logic xz, input logic sphere);
        logic [2:0] n;
        if (xz) begin
            n = 3'd3;
        end else if (sphere) begin
            n = 3'd5;
        end else begin
            n = 3'd4;
        end
        return ti == n - 3'd1;
    endfunction

endpackage

@@ hw/rtl/fpec_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fpec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/fpec_front.sv @@
// Front end: accepts requests, decodes the kind and forms queue commands.
module fpec_front (
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fpec_pkg::KIND_W-1:0]     i_kind,
    input  logic                            i_matrix_select,
    input  logic [fpec_pkg::MAT_AW-1:0]     i_element_index,
    input  logic signed [fpec_pkg::W-1:0]   i_element_value,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_x,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_y,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_z,
    input  logic [fpec_pkg::RW-1:0]         i_sphere_radius,
    input  logic                            i_xz_only,
    input  logic                            i_last_corner,
    input  logic                            i_full,
    output logic                            o_push,
    output fpec_pkg::t_cmd                  o_cmd
);
    import fpec_pkg::*;

    logic keep;

    always_comb begin
        keep         = 1'b1;
        o_cmd.op     = OP_LOAD;
        o_cmd.msel   = i_matrix_select;
        o_cmd.eidx   = i_element_index;
        o_cmd.x      = i_coord_x;
        o_cmd.y      = i_coord_y;
        o_cmd.z      = i_coord_z;
        o_cmd.radius = '0;
        o_cmd.xz     = 1'b0;
        o_cmd.sphere = 1'b0;
        o_cmd.last   = i_last_corner;
        unique case (i_kind)
            KIND_LOAD: begin
                o_cmd.x = i_element_value;
            end
            KIND_EXTRACT: begin
                o_cmd.op = OP_EXTRACT;
            end
            KIND_POINT: begin
                o_cmd.op = OP_POINT;
                o_cmd.xz = i_xz_only;
            end
            KIND_SPHERE: begin
                o_cmd.op     = OP_SPHERE;
                o_cmd.xz     = i_xz_only;
                o_cmd.sphere = 1'b1;
                o_cmd.radius = i_sphere_radius;
            end
            KIND_CORNER: begin
                o_cmd.op = OP_CORNER;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && keep;
endmodule

@@ hw/rtl/fpec_queue.sv @@
// Short command queue between the front end and the execution unit.
module fpec_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fpec_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output fpec_pkg::t_cmd  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import fpec_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_empty = r_count == '0;
endmodule

@@ hw/rtl/fpec_back.sv @@
// Execution unit: matrix storage, plane extraction sequencer and culling tests.
module fpec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fpec_pkg::t_cmd  i_head,
    input  logic            i_q_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_inside_res,
    output logic [1:0]      o_status
);
    import fpec_pkg::*;

    t_state r_state, n_state;

    t_cmd                   r_cmd;
    logic [1:0]             r_row, r_col, r_k, r_j;
    logic [2:0]             r_pl, r_ti;
    logic signed [AW-1:0]   r_acc;
    logic signed [2*W-1:0]  r_prod;
    logic signed [W-1:0]    r_w;
    logic signed [W-1:0]    r_raw [4];
    logic [2*W-1:0]         r_sq;
    logic [W+1:0]           r_rem;
    logic [W-1:0]           r_root;
    logic [W+F-1:0]         r_num, r_quo;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic                   r_degen;
    logic                   r_rd_vld;
    logic [PLANE_DEPTH-1:0] r_pl_valid;
    logic                   r_box;
    logic                   r_res_inside;
    logic [1:0]             r_res_status;
    logic                   r_out_valid;
    logic                   r_out_inside;
    logic [1:0]             r_out_status;

    logic                   mdl_we, prj_we, clip_we, pl_we;
    logic [MAT_AW-1:0]      mdl_raddr, prj_raddr, clip_raddr, clip_waddr;
    logic [PL_AW-1:0]       pl_raddr, pl_waddr;
    logic [W-1:0]           mdl_q, prj_q, clip_q, pl_q;
    logic signed [W-1:0]    clip_wdata, pl_wdata, coef;
    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [AW-1:0]   fm_ext, acc_sum, fm_y, dist_sum, neg_r, raw_sum;
    logic signed [W-1:0]    raw_v;
    logic [W-1:0]           raw_mag;
    logic [2:0]             tpl;
    logic                   out_free, reject, t_done, any_in;
    logic [W+3:0]           s_rem2, s_trial;
    logic                   s_ge;
    logic [W:0]             d_rem2;
    logic                   d_ge;

    fpec_ram #(.WIDTH(W), .DEPTH(MAT_DEPTH)) u_mdl (
        .i_clk(i_clk), .i_we(mdl_we), .i_waddr(i_head.eidx), .i_wdata(i_head.x),
        .i_raddr(mdl_raddr), .o_rdata(mdl_q)
    );
    fpec_ram #(.WIDTH(W), .DEPTH(MAT_DEPTH)) u_prj (
        .i_clk(i_clk), .i_we(prj_we), .i_waddr(i_head.eidx), .i_wdata(i_head.x),
        .i_raddr(prj_raddr), .o_rdata(prj_q)
    );
    fpec_ram #(.WIDTH(W), .DEPTH(MAT_DEPTH)) u_clip (
        .i_clk(i_clk), .i_we(clip_we), .i_waddr(clip_waddr), .i_wdata(clip_wdata),
        .i_raddr(clip_raddr), .o_rdata(clip_q)
    );
    fpec_ram #(.WIDTH(W), .DEPTH(PLANE_DEPTH)) u_plane (
        .i_clk(i_clk), .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_raddr(pl_raddr), .o_rdata(pl_q)
    );

    always_comb begin
        if (r_rd_vld) begin
            coef = $signed(pl_q);
        end else begin
            coef = '0;
        end
        fm_ext   = word_ext(sat_prod(r_prod));
        acc_sum  = r_acc + fm_ext;
        fm_y     = r_cmd.xz ? ACC_ZERO : fm_ext;
        dist_sum = r_acc + fm_y + word_ext(coef);
        neg_r    = -$signed({{(AW - RW){1'b0}}, r_cmd.radius});
        reject   = r_cmd.sphere ? (dist_sum <= neg_r) : dist_sum[AW-1];
        t_done   = reject || test_last(r_ti, r_cmd.xz, r_cmd.sphere);
        any_in   = r_box || !reject;
        tpl      = test_plane(r_ti, r_cmd.xz);
        raw_sum  = plane_add(r_pl) ? word_ext(r_w) + word_ext($signed(clip_q))
                                   : word_ext(r_w) - word_ext($signed(clip_q));
        raw_v    = sat_acc(raw_sum);
        raw_mag  = r_raw[r_j][W-1] ? $unsigned(-r_raw[r_j]) : $unsigned(r_raw[r_j]);
        s_rem2   = {r_rem, r_sq[2*W-1:2*W-2]};
        s_trial  = {2'b00, r_root, 2'b01};
        s_ge     = s_rem2 >= s_trial;
        d_rem2   = {r_rem[W-1:0], r_num[W+F-1]};
        d_ge     = d_rem2 >= {1'b0, r_root};
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        mdl_we     = 1'b0;
        prj_we     = 1'b0;
        clip_we    = 1'b0;
        pl_we      = 1'b0;
        mdl_raddr  = {r_row, r_k};
        prj_raddr  = {r_k, r_col};
        clip_waddr = {r_row, r_col};
        clip_wdata = sat_acc(acc_sum);
        clip_raddr = {r_j, 2'd3};
        pl_raddr   = {tpl, COEF_A};
        pl_waddr   = {r_pl, r_j};
        pl_wdata   = sat_quot(r_neg, r_quo);
        mul_a      = r_raw[r_j];
        mul_b      = r_raw[r_j];
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        OP_LOAD: begin
                            mdl_we = i_head.msel;
                            prj_we = !i_head.msel;
                        end
                        OP_EXTRACT: n_state = ST_CL_RD;
                        default:    n_state = ST_T_RA;
                    endcase
                end
            end
            ST_CL_RD:  n_state = ST_CL_MUL;
            ST_CL_MUL: begin
                mul_a   = $signed(mdl_q);
                mul_b   = $signed(prj_q);
                n_state = ST_CL_ACC;
            end
            ST_CL_ACC: begin
                clip_we = r_k == 2'd3;
                if (r_k == 2'd3 && r_row == 2'd3 && r_col == 2'd3) begin
                    n_state = ST_PL_RD_W;
                end else begin
                    n_state = ST_CL_RD;
                end
            end
            ST_PL_RD_W: n_state = ST_PL_RD_T;
            ST_PL_RD_T: begin
                clip_raddr = {r_j, plane_col(r_pl)};
                n_state    = ST_PL_RAW;
            end
            ST_PL_RAW:   n_state = (r_j == 2'd3) ? ST_SQRT : ST_PL_SQ;
            ST_PL_SQ:    n_state = ST_PL_SQACC;
            ST_PL_SQACC: n_state = ST_PL_RD_W;
            ST_SQRT: begin
                if (r_cnt == CW'(W - 1)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (r_root != '0) begin
                    n_state = ST_DIV_INIT;
                end else if (r_pl == LAST_PLANE) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_PL_RD_W;
                end
            end
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CW'(W + F - 1)) begin
                    n_state = ST_DIV_WR;
                end
            end
            ST_DIV_WR: begin
                pl_we = 1'b1;
                if (r_j != 2'd3) begin
                    n_state = ST_DIV_INIT;
                end else if (r_pl == LAST_PLANE) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_PL_RD_W;
                end
            end
            ST_T_RA: n_state = ST_T_RC;
            ST_T_RC: begin
                mul_a    = coef;
                mul_b    = r_cmd.x;
                pl_raddr = {tpl, COEF_C};
                n_state  = ST_T_RB;
            end
            ST_T_RB: begin
                mul_a    = coef;
                mul_b    = r_cmd.z;
                pl_raddr = {tpl, COEF_B};
                n_state  = ST_T_RD;
            end
            ST_T_RD: begin
                mul_a    = coef;
                mul_b    = r_cmd.y;
                pl_raddr = {tpl, COEF_D};
                n_state  = ST_T_EV;
            end
            ST_T_EV: begin
                if (!t_done) begin
                    n_state = ST_T_RA;
                end else if (r_cmd.op == OP_CORNER && !r_cmd.last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_rd_vld <= r_pl_valid[pl_raddr];
        unique case (r_state)
            ST_IDLE: begin
                r_cmd   <= i_head;
                r_row   <= '0;
                r_col   <= '0;
                r_k     <= '0;
                r_j     <= '0;
                r_pl    <= '0;
                r_ti    <= '0;
                r_acc   <= '0;
                r_sq    <= '0;
                r_degen <= 1'b0;
            end
            ST_CL_ACC: begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_acc          <= '0;
                    {r_row, r_col} <= {r_row, r_col} + 4'd1;
                end else begin
                    r_acc <= acc_sum;
                end
            end
            ST_PL_RD_T: r_w <= $signed(clip_q);
            ST_PL_RAW: begin
                r_raw[r_j] <= raw_v;
                r_cnt      <= '0;
                r_rem      <= '0;
                r_root     <= '0;
            end
            ST_PL_SQACC: begin
                r_sq <= r_sq + $unsigned(r_prod);
                r_j  <= r_j + 2'd1;
            end
            ST_SQRT: begin
                r_rem  <= s_ge ? (W + 2)'(s_rem2 - s_trial) : s_rem2[W+1:0];
                r_root <= {r_root[W-2:0], s_ge};
                r_sq   <= {r_sq[2*W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_LEN: begin
                r_j  <= '0;
                r_sq <= '0;
                if (r_root == '0) begin
                    r_degen      <= 1'b1;
                    r_pl         <= r_pl + 3'd1;
                    r_res_inside <= 1'b0;
                    r_res_status <= STATUS_DEGEN;
                end
            end
            ST_DIV_INIT: begin
                r_num <= {raw_mag, {F{1'b0}}};
                r_neg <= r_raw[r_j][W-1];
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= {2'b00, d_ge ? W'(d_rem2 - {1'b0, r_root}) : d_rem2[W-1:0]};
                r_quo <= {r_quo[W+F-2:0], d_ge};
                r_num <= {r_num[W+F-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_DIV_WR: begin
                r_j          <= r_j + 2'd1;
                r_res_inside <= 1'b0;
                r_res_status <= r_degen ? STATUS_DEGEN : STATUS_PLANES;
                if (r_j == 2'd3) begin
                    r_pl <= r_pl + 3'd1;
                end
            end
            ST_T_RB: r_acc <= fm_ext;
            ST_T_RD: r_acc <= acc_sum;
            ST_T_EV: begin
                r_ti         <= r_ti + 3'd1;
                r_res_status <= STATUS_TEST;
                r_res_inside <= (r_cmd.op == OP_CORNER) ? any_in : !reject;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pl_valid  <= '0;
            r_box       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DIV_WR) begin
                r_pl_valid[pl_waddr] <= 1'b1;
            end
            if (r_state == ST_LEN && r_root == '0) begin
                r_pl_valid[{r_pl, COEF_A}] <= 1'b0;
                r_pl_valid[{r_pl, COEF_B}] <= 1'b0;
                r_pl_valid[{r_pl, COEF_C}] <= 1'b0;
                r_pl_valid[{r_pl, COEF_D}] <= 1'b0;
            end
            if (r_state == ST_T_EV && t_done && r_cmd.op == OP_CORNER) begin
                r_box <= r_cmd.last ? 1'b0 : any_in;
            end
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_inside <= r_res_inside;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_pop)
        else $error("queue popped outside idle");
    a_extract_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_res_status != STATUS_TEST) |-> !r_res_inside)
        else $error("extract result reports inside");
    a_planes_stable_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_T_EV) |-> $stable(r_pl_valid))
        else $error("plane valid bits changed during a test");
`endif
endmodule

@@ hw/rtl/frustum_plane_extract_and_cull_core.sv @@
// Top level of the frustum plane extract and cull core.
// Load requests write one matrix element. An extract request forms the clip matrix through
// one shared 32x32 multiplier, each term passing read, multiply and accumulate states, then
// per plane runs a 32-step square root and four 48-step restoring divisions. Tests read
// plane coefficients through the plane store's single read port: a point test checks up to
// four planes, a sphere test five, an XZ test three and a box corner four. A two-entry
// request queue lets new requests arrive while the execution unit is busy, and the output
// register holds a result while the next request is started.
module frustum_plane_extract_and_cull_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fpec_pkg::KIND_W-1:0]     i_kind,
    input  logic                            i_matrix_select,
    input  logic [fpec_pkg::MAT_AW-1:0]     i_element_index,
    input  logic signed [fpec_pkg::W-1:0]   i_element_value,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_x,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_y,
    input  logic signed [fpec_pkg::W-1:0]   i_coord_z,
    input  logic [fpec_pkg::RW-1:0]         i_sphere_radius,
    input  logic                            i_xz_only,
    input  logic                            i_last_corner,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_inside_res,
    output logic [1:0]                      o_status
);
    import fpec_pkg::*;

    t_cmd front_cmd, q_head;
    logic push, pop, q_full, q_empty;

    fpec_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_matrix_select (i_matrix_select),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_sphere_radius (i_sphere_radius),
        .i_xz_only       (i_xz_only),
        .i_last_corner   (i_last_corner),
        .i_full          (q_full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    fpec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fpec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_inside_res (o_inside_res),
        .o_status     (o_status)
    );
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the frustum plane extract and cull core.
module testbench;
    import fpec_pkg::*;

    localparam int ONE       = 65536;
    localparam int IDLE_CAP  = 40000;
    localparam int LONG_HOLD = 3000;
    localparam int HOLD_AT   = 200;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic                msel;
        logic [MAT_AW-1:0]   eidx;
        logic signed [W-1:0] ev;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic [RW-1:0]       rad;
        logic                xz;
        logic                last;
        int                  ph;
        bit                  drain;
    } t_req;

    typedef struct {
        logic       res_in;
        logic [1:0] status;
    } t_verdict;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind = '0;
    logic                msel = 1'b0;
    logic [MAT_AW-1:0]   eidx = '0;
    logic signed [W-1:0] ev = '0;
    logic signed [W-1:0] cx = '0;
    logic signed [W-1:0] cy = '0;
    logic signed [W-1:0] cz = '0;
    logic [RW-1:0]       rad = '0;
    logic                xz = 1'b0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                inside_res;
    logic [1:0]          status;

    t_req     pending[$];
    t_verdict verdicts[$];
    t_req     cur;
    int       cur_phase = 0;
    int       err_count = 0;
    int       results_seen = 0;
    int       hold_left = 0;
    bit       held = 0;
    int       idle_cycles = 0;
    int       fill_ph = 0;
    bit       fill_drain = 0;

    logic signed [W-1:0] proj_m[16];
    logic signed [W-1:0] model_m[16];
    logic signed [W-1:0] planes[24];
    bit                  box_any;

    frustum_plane_extract_and_cull_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_matrix_select(msel),
        .i_element_index(eidx),
        .i_element_value(ev),
        .i_coord_x      (cx),
        .i_coord_y      (cy),
        .i_coord_z      (cz),
        .i_sphere_radius(rad),
        .i_xz_only      (xz),
        .i_last_corner  (last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_inside_res   (inside_res),
        .o_status       (status)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [W-1:0] sat_w(longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] qmul(logic signed [W-1:0] a, logic signed [W-1:0] b);
        longint p, m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? -p : p;
        m = m >>> F;
        return sat_w((p < 0) ? -m : m);
    endfunction

    function automatic bit extract_planes();
        logic signed [W-1:0] clip[16];
        logic signed [W-1:0] raw[4];
        longint              s, w, t, mg;
        logic [63:0]         sq, root, q;
        logic [127:0]        cand;
        bit                  degen;
        bit                  add;
        int                  col;
        degen = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                s = 0;
                for (int k = 0; k < 4; k++)
                    s += longint'(qmul(model_m[r*4+k], proj_m[k*4+c]));
                clip[r*4+c] = sat_w(s);
            end
        for (int p = 0; p < PLANE_COUNT; p++) begin
            col = p >> 1;
            add = (p == 1 || p == 2 || p == 4);
            sq = 0;
            for (int j = 0; j < 4; j++) begin
                w = clip[j*4+3];
                t = clip[j*4+col];
                raw[j] = sat_w(add ? w + t : w - t);
            end
            for (int j = 0; j < 3; j++)
                sq += 64'(longint'(raw[j]) * longint'(raw[j]));
            root = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = 128'(root | (64'd1 << b));
                if (cand * cand <= {64'd0, sq}) root = cand[63:0];
            end
            if (root == 0) degen = 1;
            for (int j = 0; j < 4; j++) begin
                if (root == 0) begin
                    planes[p*4+j] = '0;
                end else begin
                    mg = (raw[j] < 0) ? -longint'(raw[j]) : longint'(raw[j]);
                    q = 64'(mg << F) / root;
                    planes[p*4+j] = sat_w((raw[j] < 0) ? -longint'(q) : longint'(q));
                end
            end
        end
        return degen;
    endfunction

    function automatic bit survives(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                    logic signed [W-1:0] z, bit xzo, bit sph,
                                    logic [RW-1:0] r);
        int     n, p;
        longint d;
        n = xzo ? 3 : (sph ? 5 : 4);
        for (int i = 0; i < n; i++) begin
            p = xzo ? ((i == 2) ? 4 : i) : i;
            d = longint'(qmul(planes[p*4], x)) + longint'(qmul(planes[p*4+2], z))
                + longint'(planes[p*4+3]);
            if (!xzo) d += longint'(qmul(planes[p*4+1], y));
            if (sph ? (d <= -longint'({1'b0, r})) : (d < 0)) return 0;
        end
        return 1;
    endfunction

    function automatic void predict(t_req it);
        t_verdict v;
        v.res_in = 0;
        v.status = STATUS_TEST;
        case (it.kind)
            KIND_LOAD: begin
                if (it.msel) model_m[it.eidx] = it.ev;
                else proj_m[it.eidx] = it.ev;
            end
            KIND_EXTRACT: begin
                v.status = extract_planes() ? STATUS_DEGEN : STATUS_PLANES;
                verdicts.push_back(v);
            end
            KIND_POINT, KIND_SPHERE: begin
                v.res_in = survives(it.x, it.y, it.z, it.xz, it.kind == KIND_SPHERE, it.rad);
                verdicts.push_back(v);
            end
            KIND_CORNER: begin
                if (survives(it.x, it.y, it.z, 0, 0, '0)) box_any = 1;
                if (it.last) begin
                    v.res_in = box_any;
                    box_any = 0;
                    verdicts.push_back(v);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic bit idle_roll(int ph, bit sender);
        case (ph)
            1: return sender ? ($urandom_range(0, 99) < 72) : 0;
            2: return sender ? 0 : ($urandom_range(0, 99) < 72);
            3: return $urandom_range(0, 99) < 36;
            default: return 0;
        endcase
    endfunction

    task automatic add_req(logic [KIND_W-1:0] k, logic ms, logic [MAT_AW-1:0] ix,
                           logic signed [W-1:0] val, logic signed [W-1:0] x,
                           logic signed [W-1:0] y, logic signed [W-1:0] z,
                           logic [RW-1:0] r, logic xo, logic lc);
        t_req it;
        it = '{k, ms, ix, val, x, y, z, r, xo, lc, fill_ph, fill_drain};
        fill_drain = 0;
        pending.push_back(it);
    endtask

    task automatic add_load(logic ms, int ix, logic signed [W-1:0] val);
        add_req(KIND_LOAD, ms, ix[MAT_AW-1:0], val, $urandom, $urandom, $urandom,
                RW'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic add_test(logic [KIND_W-1:0] k, logic signed [W-1:0] x,
                            logic signed [W-1:0] y, logic signed [W-1:0] z,
                            logic [RW-1:0] r, logic xo, logic lc);
        add_req(k, 1'($urandom), MAT_AW'($urandom), $urandom, x, y, z, r, xo, lc);
    endtask

    function automatic logic signed [W-1:0] rnd_coord();
        if ($urandom_range(0, 9) < 7) return $signed($urandom_range(0, 1048576)) - 524288;
        return $urandom;
    endfunction

    function automatic logic signed [W-1:0] rnd_elem();
        if ($urandom_range(0, 9) < 9) return $signed($urandom_range(0, 262144)) - 131072;
        return $urandom;
    endfunction

    function automatic logic [RW-1:0] rnd_rad();
        if ($urandom_range(0, 9) < 7) return RW'($urandom_range(0, 262144));
        return RW'($urandom);
    endfunction

    initial begin
        int n, corners, extracts, pick;
        bit drained;
        // identity model, identity projection: unit cube frustum
        for (int i = 0; i < 16; i++) add_load(0, i, (i % 5 == 0) ? ONE : 0);
        for (int i = 0; i < 16; i++) add_load(1, i, (i % 5 == 0) ? ONE : 0);
        add_test(KIND_EXTRACT, 0, 0, 0, 0, 0, 0);
        add_test(KIND_POINT, 0, 0, 0, 0, 0, 0);
        add_test(KIND_POINT, 2 * ONE, 0, 0, 0, 0, 0);
        add_test(KIND_POINT, WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0);
        add_test(KIND_POINT, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0);
        add_test(KIND_POINT, 0, 5 * ONE, 0, 0, 1, 0);
        add_test(KIND_SPHERE, 0, 0, 0, '0, 0, 0);
        add_test(KIND_SPHERE, 3 * ONE, 0, 0, '1, 0, 0);
        add_test(KIND_SPHERE, 0, 0, WORD_MIN, ONE, 1, 0);
        add_test(KIND_SPHERE, 0, 0, -3 * ONE, 2 * ONE, 0, 0);
        for (int i = 0; i < 8; i++)
            add_test(KIND_CORNER, 2 * ONE + i, 2 * ONE, (i == 5) ? 0 : 2 * ONE, 0, 1, i == 7);
        add_test(KIND_CORNER, 3 * ONE, 0, 0, 0, 0, 1);
        for (int k = 5; k < 8; k++) add_test(k[KIND_W-1:0], 0, 0, 0, 0, 0, 1);
        // zero model: every normal collapses
        for (int i = 0; i < 16; i++) add_load(1, i, 0);
        add_test(KIND_EXTRACT, 0, 0, 0, 0, 0, 0);
        add_test(KIND_SPHERE, 0, 0, 0, '0, 0, 0);
        add_test(KIND_POINT, WORD_MIN, 0, WORD_MAX, 0, 0, 0);
        for (int i = 0; i < 16; i++) add_load(1, i, (i % 5 == 0) ? ONE : 0);
        add_test(KIND_EXTRACT, 0, 0, 0, 0, 0, 0);

        n = 0;
        extracts = 0;
        drained = 0;
        while (n < 1000) begin
            fill_ph = (n / 250) % 4;
            if (n >= 500 && !drained) begin
                fill_drain = 1;
                drained = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2 && extracts < 10) begin
                for (int i = 0; i < 16; i++) add_load(0, i, rnd_elem());
                for (int i = 0; i < 16; i++) add_load(1, i, rnd_elem());
                add_test(KIND_EXTRACT, 0, 0, 0, 0, 0, 0);
                extracts++;
                n += 33;
            end else if (pick < 5) begin
                add_load(1'($urandom), $urandom_range(0, 15), rnd_elem());
                n++;
            end else if (pick < 7) begin
                add_test(KIND_W'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                         RW'($urandom), 1'($urandom), 1'($urandom));
                n++;
            end else if (pick < 45) begin
                add_test(KIND_POINT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_rad(),
                         1'($urandom), 1'($urandom));
                n++;
            end else if (pick < 80) begin
                add_test(KIND_SPHERE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_rad(),
                         1'($urandom), 1'($urandom));
                n++;
            end else begin
                corners = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 8;
                for (int i = 0; i < corners; i++)
                    add_test(KIND_CORNER, rnd_coord(), rnd_coord(), rnd_coord(), rnd_rad(),
                             1'($urandom), i == corners - 1);
                n += corners;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending.size() > 0 || in_valid || verdicts.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_count == 0) $display("frustum_plane_extract_and_cull_core test passed");
        else $display("frustum_plane_extract_and_cull_core test failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            proj_m[i] = '0;
            model_m[i] = '0;
        end
        for (int i = 0; i < 24; i++) planes[i] = '0;
        box_any = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && (!in_valid || !in_stall)) begin
            if (in_valid) predict(cur);
            if (pending.size() > 0 && (!pending[0].drain || verdicts.size() == 0)
                    && !idle_roll(pending[0].ph, 1)) begin
                cur = pending.pop_front();
                cur_phase <= cur.ph;
                kind      <= cur.kind;
                msel      <= cur.msel;
                eidx      <= cur.eidx;
                ev        <= cur.ev;
                cx        <= cur.x;
                cy        <= cur.y;
                cz        <= cur.z;
                rad       <= cur.rad;
                xz        <= cur.xz;
                last      <= cur.last;
                in_valid  <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (verdicts.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = verdicts.pop_front();
                    if (inside_res !== want.res_in)
                        report_mismatch("inside_res", inside_res, want.res_in);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (results_seen == HOLD_AT && !held) begin
                held = 1;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end else begin
                out_stall <= idle_roll(cur_phase, 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_CAP) begin
                $display("frustum_plane_extract_and_cull_core test failed");
                $finish;
            end
        end
    end

endmodule
